/* rtl/fbpa_pkg.sv */
// Shared types and constants for the fixed block pool allocator.
package fbpa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;

    localparam logic       FUNC_ALLOC   = 1'b0;
    localparam logic       FUNC_FREE    = 1'b1;
    localparam logic [1:0] POOL_SHORT   = 2'd0;
    localparam logic [1:0] POOL_LONG    = 2'd1;
    localparam logic [1:0] POOL_LARGE   = 2'd2;
    localparam logic [1:0] POOL_INVALID = 2'd3;

    typedef enum logic [1:0] {
        ST_DONE         = 2'd0,
        ST_BAD_POOL     = 2'd1,
        ST_EMPTY        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    typedef struct packed {
        logic             func;
        logic [1:0]       pool_type;
        logic [IDX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] granted_index;
        logic [CNT_W-1:0] free_blocks;
    } rsp_t;

endpackage

/* rtl/fbpa_core.sv */
// Free map, free count and per-request grant/release logic.
module fbpa_core (
    input  logic          clk,
    input  logic          rst_n,
    input  fbpa_pkg::req_t req,
    input  logic          upd,
    output fbpa_pkg::rsp_t rsp
);
    import fbpa_pkg::*;

    logic [NUM_BLOCKS-1:0] map_reg;
    logic [NUM_BLOCKS-1:0] map_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  found;
    logic [IDX_W-1:0]      first;

    // Find the lowest free block, then decide the request outcome
    always_comb
    begin
        found      = 1'b0;
        first      = '0;
        map_next   = map_reg;
        count_next = count_reg;
        rsp        = '0;
        for (int i = NUM_BLOCKS - 1; i >= 0; i--)
        begin
            if (map_reg[i])
            begin
                found = 1'b1;
                first = IDX_W'(i);
            end
        end
        if (req.func == FUNC_ALLOC)
        begin
            if (req.pool_type != POOL_SHORT)
            begin
                rsp.status = ST_BAD_POOL;
            end
            else if (found)
            begin
                map_next[first]   = 1'b0;
                count_next        = count_reg - CNT_W'(1);
                rsp.status        = ST_DONE;
                rsp.granted_index = first;
            end
            else
            begin
                rsp.status = ST_EMPTY;
            end
        end
        else
        begin
            if ((int'(req.block_index) >= NUM_BLOCKS) || map_reg[req.block_index])
            begin
                rsp.status = ST_ALREADY_FREE;
            end
            else
            begin
                map_next[req.block_index] = 1'b1;
                count_next                = count_reg + CNT_W'(1);
                rsp.status                = ST_DONE;
            end
        end
        rsp.free_blocks = count_next;
    end

    // Commit map and count when the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '1;
            count_reg <= CNT_W'(NUM_BLOCKS);
        end
        else if (upd)
        begin
            map_reg   <= map_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/fixed_block_pool_allocator_top.sv */
// Top level of the fixed block pool allocator: request and result registers.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+------------------------------------------
//   request | req_valid | req_ready | req: func, pool_type, block_index
//   result  | rsp_valid | rsp_ready | rsp: status, granted_index, free_blocks
//
// One request per cycle is sustained while results are not stalled; a result
// passes the request register and then the result register before it is valid.
// The map and count update in the cycle the request moves to the result
// register, so the next request always sees the prior request's effect.
// Reset makes every block free with no clearing pass; a request can be taken
// in the first cycle after reset. A stalled result holds the result register;
// the request register takes one more request and then holds, dropping req_ready.
module fixed_block_pool_allocator_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  fbpa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output fbpa_pkg::rsp_t rsp
);
    import fbpa_pkg::*;

    logic  s1_valid_reg;
    req_t  s1_req_reg;
    logic  s2_valid_reg;
    rsp_t  s2_rsp_reg;
    rsp_t  core_rsp;
    logic  s2_open;
    logic  advance;

    // Advance stage 1 when the result register is empty or being drained
    assign s2_open   = !s2_valid_reg || rsp_ready;
    assign advance   = s1_valid_reg && s2_open;
    assign req_ready = !s1_valid_reg || s2_open;

    fbpa_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (s1_req_reg),
        .upd   (advance),
        .rsp   (core_rsp)
    );

    // Hold request and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s2_open)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Load payload registers on transfer or advance
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_req_reg <= req;
        end
        if (advance)
        begin
            s2_rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = s2_valid_reg;
    assign rsp       = s2_rsp_reg;

endmodule

/* rtl/fbpa_checker.sv */
// Port-level checks for the fixed block pool allocator, bound to the top level.
module fbpa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input fbpa_pkg::rsp_t rsp
);
    import fbpa_pkg::*;

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Free count never exceeds the pool size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp.free_blocks) <= NUM_BLOCKS))
        else $error("free count above pool size");

    // Failed requests grant nothing
    a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_DONE) |-> (rsp.granted_index == '0))
        else $error("grant index set on failed request");

    // Exhausted pool reports zero free blocks
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_EMPTY) |-> (rsp.free_blocks == '0))
        else $error("empty pool with nonzero free count");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

/* sim/tb.sv */
// Self-checking testbench for the fixed block pool allocator top level.
module tb;
    import fbpa_pkg::*;

    typedef struct packed {
        req_t    r;
        logic    typed;
        rsp_t    e;
    } step_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Allocator state as the checker sees it
    logic [NUM_BLOCKS-1:0] free_map;
    logic [CNT_W-1:0]      free_total;

    rsp_t  pending_rsp[$];
    step_t directed_steps[$];

    int errors;
    int gap_pct;
    int stall_pct;
    int stall_left;
    bit calm;
    int n_granted;
    int n_bad_pool;
    int n_exhausted;
    int n_double_free;

    fixed_block_pool_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Apply one request to the allocator state and return its result
    function automatic rsp_t serve_request(input req_t r);
        rsp_t o;
        int   i;
        o.status        = ST_DONE;
        o.granted_index = '0;
        if (r.func == FUNC_ALLOC)
        begin
            if (r.pool_type != POOL_SHORT)
                o.status = ST_BAD_POOL;
            else if (free_map == '0)
                o.status = ST_EMPTY;
            else
            begin
                // lowest-numbered free block wins
                for (i = NUM_BLOCKS - 1; i >= 0; i--)
                    if (free_map[i])
                        o.granted_index = IDX_W'(i);
                free_map[o.granted_index] = 1'b0;
                free_total = free_total - CNT_W'(1);
            end
        end
        else
        begin
            if (int'(r.block_index) >= NUM_BLOCKS || free_map[r.block_index])
                o.status = ST_ALREADY_FREE;
            else
            begin
                free_map[r.block_index] = 1'b1;
                free_total = free_total + CNT_W'(1);
            end
        end
        o.free_blocks = free_total;
        return o;
    endfunction

    function automatic step_t mk(input logic f, input logic [1:0] pool,
                                 input logic [IDX_W-1:0] idx, input logic typed,
                                 input status_t st, input logic [IDX_W-1:0] granted,
                                 input logic [CNT_W-1:0] count);
        step_t s;
        s.r.func        = f;
        s.r.pool_type   = pool;
        s.r.block_index = idx;
        s.typed         = typed;
        s.e.status        = st;
        s.e.granted_index = granted;
        s.e.free_blocks   = count;
        return s;
    endfunction

    // Pick a request: mostly legal traffic, with refused pools and stray frees mixed in
    function automatic req_t next_random_request(input int alloc_bias);
        req_t             r;
        int               roll;
        logic [IDX_W-1:0] taken[$];
        int               i;
        r.func        = FUNC_ALLOC;
        r.pool_type   = POOL_SHORT;
        r.block_index = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
        roll          = $urandom_range(0, 99);
        for (i = 0; i < NUM_BLOCKS; i++)
            if (!free_map[i])
                taken.push_back(IDX_W'(i));
        if (roll < 6)
            r.pool_type = 2'($urandom_range(POOL_LONG, POOL_INVALID));
        else if (roll < 12)
        begin
            r.func      = FUNC_FREE;
            r.pool_type = 2'($urandom_range(POOL_SHORT, POOL_INVALID));
        end
        else if ($urandom_range(0, 99) >= alloc_bias && taken.size() != 0)
        begin
            r.func        = FUNC_FREE;
            r.pool_type   = 2'($urandom_range(POOL_SHORT, POOL_INVALID));
            r.block_index = taken[$urandom_range(0, taken.size() - 1)];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("ERROR %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Drive one request and hold it until the transfer; predict at the transfer
    task automatic send_req(input step_t s);
        rsp_t want;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= s.r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        want = serve_request(s.r);
        pending_rsp.push_back(s.typed ? s.e : want);
    endtask

    // Stall the result side in bursts
    always @(posedge clk)
    begin
        if (calm)
        begin
            stall_left <= 0;
            rsp_ready  <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 9);
            rsp_ready  <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("ERROR %0t: result with no request outstanding", $realtime);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.granted_index !== want.granted_index)
                    report_mismatch("granted_index", rsp.granted_index, want.granted_index);
                if (rsp.free_blocks !== want.free_blocks)
                    report_mismatch("free_blocks", rsp.free_blocks, want.free_blocks);
                case (want.status)
                    ST_DONE:         n_granted++;
                    ST_BAD_POOL:     n_bad_pool++;
                    ST_EMPTY:        n_exhausted++;
                    ST_ALREADY_FREE: n_double_free++;
                    default:         ;
                endcase
            end
        end
    end

    // Guard against a hung handshake
    initial
    begin
        #2000000;
        $display("fixed_block_pool_allocator_top: mismatch");
        $finish;
    end

    initial
    begin
        int    k;
        int    bias;
        step_t s;
        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        rsp_ready  = 1'b0;
        stall_left = 0;
        errors     = 0;
        calm       = 1'b0;
        gap_pct    = 20;
        stall_pct  = 20;
        free_map   = '1;
        free_total = CNT_W'(NUM_BLOCKS);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: refused pools, frees of free blocks, drain to empty, free and reallocate
        directed_steps.push_back(mk(FUNC_ALLOC, POOL_LONG, 4'h0, 1'b1,
                                    ST_BAD_POOL, 4'd0, 5'd16));
        directed_steps.push_back(mk(FUNC_ALLOC, POOL_LARGE, 4'hA, 1'b1,
                                    ST_BAD_POOL, 4'd0, 5'd16));
        directed_steps.push_back(mk(FUNC_ALLOC, POOL_INVALID, 4'h5, 1'b1,
                                    ST_BAD_POOL, 4'd0, 5'd16));
        directed_steps.push_back(mk(FUNC_FREE, POOL_SHORT, 4'hF, 1'b1,
                                    ST_ALREADY_FREE, 4'd0, 5'd16));
        directed_steps.push_back(mk(FUNC_FREE, POOL_INVALID, 4'h0, 1'b1,
                                    ST_ALREADY_FREE, 4'd0, 5'd16));
        directed_steps.push_back(mk(FUNC_ALLOC, POOL_SHORT, 4'hF, 1'b1,
                                    ST_DONE, 4'd0, 5'd15));
        for (k = 1; k < NUM_BLOCKS; k++)
            directed_steps.push_back(mk(FUNC_ALLOC, POOL_SHORT, IDX_W'(k), 1'b0,
                                        ST_DONE, 4'd0, 5'd0));
        directed_steps.push_back(mk(FUNC_ALLOC, POOL_SHORT, 4'h0, 1'b1,
                                    ST_EMPTY, 4'd0, 5'd0));
        directed_steps.push_back(mk(FUNC_ALLOC, POOL_INVALID, 4'h0, 1'b1,
                                    ST_BAD_POOL, 4'd0, 5'd0));
        directed_steps.push_back(mk(FUNC_FREE, POOL_SHORT, 4'hF, 1'b1,
                                    ST_DONE, 4'd0, 5'd1));
        directed_steps.push_back(mk(FUNC_FREE, POOL_SHORT, 4'hF, 1'b1,
                                    ST_ALREADY_FREE, 4'd0, 5'd1));
        directed_steps.push_back(mk(FUNC_ALLOC, POOL_SHORT, 4'h0, 1'b1,
                                    ST_DONE, 4'd15, 5'd0));
        directed_steps.push_back(mk(FUNC_FREE, POOL_LONG, 4'h7, 1'b0,
                                    ST_DONE, 4'd0, 5'd0));
        directed_steps.push_back(mk(FUNC_ALLOC, POOL_SHORT, 4'h0, 1'b0,
                                    ST_DONE, 4'd0, 5'd0));
        foreach (directed_steps[i])
            send_req(directed_steps[i]);

        // Random traffic in phases of differing allocate bias and idling
        for (k = 0; k < 1250; k++)
        begin
            if (k % 100 == 0)
            begin
                bias      = (k / 100) % 3 == 0 ? 80 : ((k / 100) % 3 == 1 ? 25 : 55);
                gap_pct   = (k / 100) % 4 == 2 ? 0 : $urandom_range(5, 40);
                stall_pct = (k / 100) % 4 == 3 ? 0 : $urandom_range(5, 40);
            end
            if (k == 600)
            begin
                // hold off until every result is back
                req_valid <= 1'b0;
                while (pending_rsp.size() != 0)
                    @(posedge clk);
            end
            if (k == 1100)
                calm = 1'b1;
            s       = '0;
            s.r     = next_random_request(bias);
            s.typed = 1'b0;
            send_req(s);
        end
        req_valid <= 1'b0;

        // Drain and let any stray result show up
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d successful requests, %0d refused pools, %0d on an empty pool,",
                 n_granted, n_bad_pool, n_exhausted);
        $display("and %0d frees of blocks that were already free.", n_double_free);
        if (errors == 0)
            $display("fixed_block_pool_allocator_top: match");
        else
            $display("fixed_block_pool_allocator_top: mismatch");
        $finish;
    end

endmodule

/* fixed_block_pool_allocator_top.f */
rtl/fbpa_pkg.sv
rtl/fbpa_core.sv
rtl/fixed_block_pool_allocator_top.sv
rtl/fbpa_checker.sv
sim/tb.sv
